>>> rtl/deque_with_pop_max_macros.svh
// Assertion macros shared by the deque RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef DEQUE_WITH_POP_MAX_MACROS_SVH
`define DEQUE_WITH_POP_MAX_MACROS_SVH

`ifndef SYNTHESIS

// Expression holds at every clock edge outside reset.
`define DQPM_ASSERT(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Antecedent in a cycle implies consequent in the same cycle.
`define DQPM_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent in a cycle implies consequent in the next cycle.
`define DQPM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define DQPM_ASSERT(label, clk, rst, expr, msg)
`define DQPM_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define DQPM_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

>>> rtl/dqpm_pkg.sv
// Shared types, constants and ring index helper for the deque.
// No dependencies; imported by the front, back and top-level deque modules.
package dqpm_pkg;

   localparam int DEPTH    = 16;
   localparam int DATA_W   = 32;
   localparam int PTR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int SUM_W    = CNT_W + 1;
   localparam int CMD_W    = 3;
   localparam int STATUS_W = 2;

   // Command queue between the front and back halves
   localparam int CQ_DEPTH = 2;
   localparam int CQ_PTR_W = (CQ_DEPTH > 1) ? $clog2(CQ_DEPTH) : 1;
   localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);

   // Command codes on the request port
   localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
   localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_POP_MAX    = 3'd4;
   localparam logic [CMD_W-1:0] CMD_PEEK_BACK  = 3'd5;
   localparam logic [CMD_W-1:0] CMD_PEEK_FRONT = 3'd6;

   // Status codes on the response port
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   // Classified operation carried to the back half
   typedef enum logic [2:0] {
      OP_PUSH_BACK,
      OP_PUSH_FRONT,
      OP_POP_BACK,
      OP_POP_FRONT,
      OP_POP_MAX,
      OP_PEEK_BACK,
      OP_PEEK_FRONT,
      OP_NOP
   } op_type;

   typedef struct packed {
      logic                     valid;
      op_type                   op;
      logic signed [DATA_W-1:0] value;
   } cmd_beat_type;

   // Ring slot at a given offset from the front; offset never exceeds DEPTH
   function automatic logic [PTR_W-1:0] ring_slot(input logic [PTR_W-1:0] base,
                                                 input logic [CNT_W-1:0] off);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(base) + SUM_W'(off);
      if (sum >= SUM_W'(DEPTH)) begin
         sum = sum - SUM_W'(DEPTH);
      end
      return sum[PTR_W-1:0];
   endfunction

endpackage

>>> rtl/dqpm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dqpm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/dqpm_front.sv
// Front half: accepts request beats, decodes the command code and queues them.
// Depends on dqpm_pkg and the assertion macro header.
`include "deque_with_pop_max_macros.svh"

module dqpm_front
   import dqpm_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   output logic                     full,
   input  logic [CMD_W-1:0]         req_cmd,
   input  logic signed [DATA_W-1:0] req_push_value,
   output cmd_beat_type             cmd,
   input  logic                     cmd_take
);

   op_type                   op_q_ff  [CQ_DEPTH];
   logic signed [DATA_W-1:0] val_q_ff [CQ_DEPTH];
   logic [CQ_PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [CQ_PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CQ_CNT_W-1:0]      fill_ff, fill_in;
   op_type                   op_dec;
   logic                     do_wr;
   logic                     do_rd;

   // Command decode
   always_comb begin
      unique case (req_cmd)
         CMD_PUSH_BACK:  op_dec = OP_PUSH_BACK;
         CMD_PUSH_FRONT: op_dec = OP_PUSH_FRONT;
         CMD_POP_BACK:   op_dec = OP_POP_BACK;
         CMD_POP_FRONT:  op_dec = OP_POP_FRONT;
         CMD_POP_MAX:    op_dec = OP_POP_MAX;
         CMD_PEEK_BACK:  op_dec = OP_PEEK_BACK;
         CMD_PEEK_FRONT: op_dec = OP_PEEK_FRONT;
         default:        op_dec = OP_NOP;
      endcase
   end

   assign full  = (fill_ff == CQ_CNT_W'(CQ_DEPTH));
   assign do_wr = push && !full;
   assign do_rd = cmd_take && (fill_ff != '0);

   // Queue pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         fill_in = fill_ff + 1'b1;
      end else if (!do_wr && do_rd) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Queue payload, no reset
   always_ff @(posedge clock) begin
      if (do_wr) begin
         op_q_ff[wr_ptr_ff]  <= op_dec;
         val_q_ff[wr_ptr_ff] <= req_push_value;
      end
   end

   assign cmd.valid = (fill_ff != '0);
   assign cmd.op    = op_q_ff[rd_ptr_ff];
   assign cmd.value = val_q_ff[rd_ptr_ff];

   `DQPM_ASSERT(a_fill_range, clock, reset, fill_ff <= CQ_CNT_W'(CQ_DEPTH), "queue overfill")
   `DQPM_ASSERT_IMPL(a_take_valid, clock, reset, cmd_take, fill_ff != '0, "take from empty queue")

endmodule

>>> rtl/dqpm_back.sv
// Back half: executes queued commands on the entry ring and holds the response beat.
// Depends on dqpm_pkg and the assertion macro header; drives the entry RAM.
`include "deque_with_pop_max_macros.svh"

module dqpm_back
   import dqpm_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_beat_type             cmd,
   output logic                     cmd_take,
   output logic                     ram_wr_en,
   output logic [PTR_W-1:0]         ram_wr_addr,
   output logic [DATA_W-1:0]        ram_wr_data,
   output logic [PTR_W-1:0]         ram_rd_addr,
   input  logic [DATA_W-1:0]        ram_rd_data,
   output logic                     empty,
   input  logic                     pop,
   output logic signed [DATA_W-1:0] rsp_result_value,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic                     rsp_now_empty
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_SCAN,
      ST_SHIFT
   } state_type;

   state_type                state_ff, state_in;
   logic [PTR_W-1:0]         head_ff, head_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CNT_W-1:0]         off_ff, off_in;
   logic [CNT_W-1:0]         best_off_ff, best_off_in;
   logic signed [DATA_W-1:0] best_val_ff, best_val_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic [STATUS_W-1:0]      rsp_status_ff, rsp_status_in;
   logic                     rsp_now_empty_ff, rsp_now_empty_in;

   logic                     rsp_set;
   logic [CNT_W-1:0]         rd_off;
   logic [CNT_W-1:0]         cnt_m1;
   logic [PTR_W-1:0]         head_dec;
   logic [PTR_W-1:0]         head_inc;
   logic signed [DATA_W-1:0] rd_val;
   logic                     nb_take;
   logic [CNT_W-1:0]         nb_off;
   logic signed [DATA_W-1:0] nb_val;

   assign cnt_m1   = count_ff - 1'b1;
   assign head_dec = (head_ff == '0) ? PTR_W'(DEPTH - 1) : head_ff - 1'b1;
   assign head_inc = ring_slot(head_ff, CNT_W'(1));
   assign rd_val   = $signed(ram_rd_data);

   // Max scan compare: first entry always wins, later ones only if strictly larger
   assign nb_take = (off_ff == '0) || (rd_val > best_val_ff);
   assign nb_off  = nb_take ? off_ff : best_off_ff;
   assign nb_val  = nb_take ? rd_val : best_val_ff;

   // Sequencer
   always_comb begin
      state_in         = state_ff;
      head_in          = head_ff;
      count_in         = count_ff;
      off_in           = off_ff;
      best_off_in      = best_off_ff;
      best_val_in      = best_val_ff;
      rsp_value_in     = rsp_value_ff;
      rsp_status_in    = rsp_status_ff;
      rsp_now_empty_in = rsp_now_empty_ff;
      rsp_set          = 1'b0;
      cmd_take         = 1'b0;
      ram_wr_en        = 1'b0;
      ram_wr_addr      = ring_slot(head_ff, count_ff);
      ram_wr_data      = cmd.value;
      rd_off           = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.valid && !rsp_valid_ff) begin
               cmd_take         = 1'b1;
               rsp_set          = 1'b1;
               rsp_value_in     = '0;
               rsp_status_in    = STATUS_OK;
               rsp_now_empty_in = (count_ff == '0);
               case (cmd.op) inside
                  OP_PUSH_BACK, OP_PUSH_FRONT: begin
                     if (count_ff == CNT_W'(DEPTH)) begin
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        ram_wr_en        = 1'b1;
                        count_in         = count_ff + 1'b1;
                        rsp_now_empty_in = 1'b0;
                        if (cmd.op == OP_PUSH_FRONT) begin
                           ram_wr_addr = head_dec;
                           head_in     = head_dec;
                        end
                     end
                  end
                  OP_NOP: begin
                  end
                  default: begin
                     if (count_ff == '0) begin
                        rsp_status_in = STATUS_EMPTY;
                     end else begin
                        // Result comes from the registered RAM read in ST_READ; pop-max goes to ST_SCAN
                        rsp_set  = 1'b0;
                        state_in = ST_READ;
                        case (cmd.op)
                           OP_POP_BACK: begin
                              rd_off   = cnt_m1;
                              count_in = cnt_m1;
                           end
                           OP_POP_FRONT: begin
                              head_in  = head_inc;
                              count_in = cnt_m1;
                           end
                           OP_PEEK_BACK: begin
                              rd_off = cnt_m1;
                           end
                           OP_POP_MAX: begin
                              off_in   = '0;
                              state_in = ST_SCAN;
                           end
                           default: begin
                           end
                        endcase
                     end
                  end
               endcase
            end
         end

         ST_READ: begin
            rsp_set          = 1'b1;
            rsp_value_in     = rd_val;
            rsp_status_in    = STATUS_OK;
            rsp_now_empty_in = (count_ff == '0);
            state_in         = ST_IDLE;
         end

         ST_SCAN: begin
            best_off_in = nb_off;
            best_val_in = nb_val;
            if (off_ff == cnt_m1) begin
               // Prime the shift with the entry behind the winner
               rd_off   = nb_off + 1'b1;
               off_in   = nb_off;
               state_in = ST_SHIFT;
            end else begin
               rd_off = off_ff + 1'b1;
               off_in = off_ff + 1'b1;
            end
         end

         ST_SHIFT: begin
            if (off_ff + 1'b1 < count_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = ring_slot(head_ff, off_ff);
               ram_wr_data = ram_rd_data;
               rd_off      = off_ff + CNT_W'(2);
               off_in      = off_ff + 1'b1;
            end else begin
               count_in         = cnt_m1;
               rsp_set          = 1'b1;
               rsp_value_in     = best_val_ff;
               rsp_status_in    = STATUS_OK;
               rsp_now_empty_in = (cnt_m1 == '0);
               state_in         = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = rsp_set || (rsp_valid_ff && !pop);
   end

   assign ram_rd_addr = ring_slot(head_ff, rd_off);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      off_ff           <= off_in;
      best_off_ff      <= best_off_in;
      best_val_ff      <= best_val_in;
      rsp_value_ff     <= rsp_value_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_now_empty_ff <= rsp_now_empty_in;
   end

   assign empty            = !rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_now_empty    = rsp_now_empty_ff;

   `DQPM_ASSERT(a_count_range, clock, reset, count_ff <= CNT_W'(DEPTH), "count above depth")
   `DQPM_ASSERT_IMPL(a_busy_slot_free, clock, reset, state_ff != ST_IDLE, !rsp_valid_ff, "slot busy")
   `DQPM_ASSERT_IMPL(a_scan_bounds, clock, reset, state_ff == ST_SCAN, off_ff < count_ff, "bad scan")
   `DQPM_ASSERT_NEXT(a_resp_after_read, clock, reset, state_ff == ST_READ, rsp_valid_ff, "no response")

endmodule

>>> rtl/deque_with_pop_max.sv
// Top level of the bounded deque with pop-max: front decoder, back executor, entry RAM.
// Depends on dqpm_pkg, dqpm_front, dqpm_back and dqpm_ram.
//
//   channel   ports                                   handshake
//   request   req_cmd, req_push_value                 push / full
//   response  rsp_result_value, rsp_status,           empty / pop
//             rsp_now_empty
//
// Push, error and unused commands complete in ST_IDLE; pop and peek pass through ST_READ.
// Pop-max reads every entry in ST_SCAN, then moves the entries behind the winner forward
// in ST_SHIFT, both through the single read port of the entry RAM.
// Reset clears the ring pointers, the command queue and the response slot; entry RAM
// holds no reset and needs no clearing pass.
// A two-beat command queue keeps push open while the back end works or the response
// waits; the back end starts a command only once the response slot is empty.
module deque_with_pop_max
   import dqpm_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   output logic                     full,
   input  logic [CMD_W-1:0]         req_cmd,
   input  logic signed [DATA_W-1:0] req_push_value,
   output logic                     empty,
   input  logic                     pop,
   output logic signed [DATA_W-1:0] rsp_result_value,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic                     rsp_now_empty
);

   cmd_beat_type      cmd;
   logic              cmd_take;
   logic              ram_wr_en;
   logic [PTR_W-1:0]  ram_wr_addr;
   logic [DATA_W-1:0] ram_wr_data;
   logic [PTR_W-1:0]  ram_rd_addr;
   logic [DATA_W-1:0] ram_rd_data;

   // Request decode and queue
   dqpm_front u_front (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_cmd        (req_cmd),
      .req_push_value (req_push_value),
      .cmd            (cmd),
      .cmd_take       (cmd_take)
   );

   // Command execution and response slot
   dqpm_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .cmd_take         (cmd_take),
      .ram_wr_en        (ram_wr_en),
      .ram_wr_addr      (ram_wr_addr),
      .ram_wr_data      (ram_wr_data),
      .ram_rd_addr      (ram_rd_addr),
      .ram_rd_data      (ram_rd_data),
      .empty            (empty),
      .pop              (pop),
      .rsp_result_value (rsp_result_value),
      .rsp_status       (rsp_status),
      .rsp_now_empty    (rsp_now_empty)
   );

   // Entry ring storage
   dqpm_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_entries (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule
